// File: sv/pfe_pkg.sv
// Shared constants and types for the postfix expression evaluator.
package pfe_pkg;

  localparam int StackDepth = 128;
  localparam int PtrW = $clog2(StackDepth);
  localparam int CntW = $clog2(StackDepth + 1);

  localparam logic [7:0] SymZero  = 8'h30;
  localparam logic [7:0] SymNine  = 8'h39;
  localparam logic [7:0] SymAdd   = 8'h2B;
  localparam logic [7:0] SymSub   = 8'h2D;
  localparam logic [7:0] SymMul   = 8'h2A;
  localparam logic [7:0] SymDiv   = 8'h2F;
  localparam logic [7:0] SymXor   = 8'h5E;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StBadSym = 2'd1;
  localparam logic [1:0] StDivZero = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_POP_R, S_POP_WAIT, S_POP_L, S_EXEC, S_DIV, S_FIN_POP, S_FIN_WAIT, S_OUT
  } pfe_state_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_XOR, OP_BAD
  } pfe_op_t;

  // controller -> datapath
  typedef struct packed {
    logic     load;      // capture symbol
    logic     push_dig;  // push digit
    logic     pop_rhs;   // pop into rhs
    logic     pop_lhs;   // pop into lhs
    logic     exec;      // apply non-divide op
    logic     div_start;
    logic     div_push;  // push quotient
    logic     pop_fin;   // pop final value
    logic     fin_take;  // latch result
    logic     clear;     // clear stack, flags
  } pfe_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic    is_digit;
    pfe_op_t op;
    logic    rhs_zero;
    logic    div_done;
  } pfe_sts_t;

endpackage

// File: sv/pfe_if.sv
// Valid/ready channel interfaces for the evaluator.
interface pfe_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_expr;
  modport source (output valid, symbol, end_of_expr, input ready);
  modport sink (input valid, symbol, end_of_expr, output ready);
endinterface

interface pfe_out_if (input logic clk);
  logic              valid;
  logic              ready;
  logic signed [31:0] value;
  logic [1:0]        status;
  logic              underflow_seen;
  logic              overflow_seen;
  modport source (output valid, value, status, underflow_seen, overflow_seen, input ready);
  modport sink (input valid, value, status, underflow_seen, overflow_seen, output ready);
endinterface

// File: sv/pfe_div.sv
// Iterative signed truncating divider, one quotient bit per cycle.
module pfe_div import pfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quot
);
  logic [31:0] rem, q, d;
  logic [5:0]  cnt;
  logic        busy, neg;
  logic [32:0] trial;

  assign trial = {rem[31:0], q[31]} - {1'b0, d};

  // step restoring division
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        rem  <= '0;
        q    <= num[31] ? (32'd0 - num) : num;
        d    <= den[31] ? (32'd0 - den) : den;
        neg  <= num[31] ^ den[31];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          q   <= {q[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], q[31]};
          q   <= {q[30:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? (32'd0 - q) : q;
endmodule

// File: sv/pfe_datapath.sv
// Stack memory, operand registers, ALU and result register.
module pfe_datapath import pfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  pfe_cmd_t    cmd,
  output pfe_sts_t    sts,
  input  logic [7:0]  symbol,
  output logic [31:0] res_value,
  output logic [1:0]  res_status,
  output logic        res_under,
  output logic        res_over
);
  logic [31:0]     mem [StackDepth];
  logic [31:0]     rd_data;
  logic [CntW-1:0] count;
  logic [7:0]      sym;
  logic [31:0]     rhs, lhs, fin;
  logic [1:0]      err;
  logic            under, over;
  logic            pop_any, empty, full, do_push;
  logic [31:0]     push_val, alu;
  logic            div_done;
  logic [31:0]     quot;
  pfe_op_t         op;

  assign empty   = (count == '0);
  assign full    = (count == CntW'(StackDepth));
  assign pop_any = cmd.pop_rhs | cmd.pop_lhs | cmd.pop_fin;

  // decode operator
  always_comb begin
    case (sym)
      SymAdd:  op = OP_ADD;
      SymSub:  op = OP_SUB;
      SymMul:  op = OP_MUL;
      SymDiv:  op = OP_DIV;
      SymXor:  op = OP_XOR;
      default: op = OP_BAD;
    endcase
  end

  always_comb begin
    case (op)
      OP_ADD:  alu = lhs + rhs;
      OP_SUB:  alu = lhs - rhs;
      OP_MUL:  alu = lhs * rhs;
      OP_XOR:  alu = lhs ^ rhs;
      default: alu = '0;
    endcase
  end

  // digits '0'..'9' carry their value in the low nibble
  assign do_push  = cmd.push_dig | cmd.div_push | (cmd.exec && op != OP_BAD && op != OP_DIV);
  assign push_val = cmd.push_dig ? {28'd0, sym[3:0]}
                  : cmd.div_push ? quot : alu;

  // stack memory: write on push, registered read of top
  always_ff @(posedge clk) begin
    if (do_push && !full) mem[count[PtrW-1:0]] <= push_val;
    rd_data <= mem[PtrW'(count - CntW'(1))];
  end

  // pointer and flags
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      err   <= StOk;
      under <= 1'b0;
      over  <= 1'b0;
    end else begin
      if (do_push) begin
        if (full) over <= 1'b1;
        else count <= count + CntW'(1);
      end else if (pop_any) begin
        if (empty) under <= 1'b1;
        else count <= count - CntW'(1);
      end
      if (cmd.exec && err == StOk) begin
        if (op == OP_BAD) err <= StBadSym;
        else if (op == OP_DIV && rhs == '0) err <= StDivZero;
      end
    end
  end

  // operand registers; pop reads registered top, valid in the cycle after the pointer settles
  always_ff @(posedge clk) begin
    if (cmd.load) sym <= symbol;
    if (cmd.pop_rhs) rhs <= empty ? 32'hFFFF_FFFF : rd_data;
    if (cmd.pop_lhs) lhs <= empty ? 32'hFFFF_FFFF : rd_data;
    if (cmd.pop_fin) fin <= empty ? 32'hFFFF_FFFF : rd_data;
    if (cmd.fin_take) begin
      res_value  <= fin;
      res_status <= err;
      res_under  <= under;
      res_over   <= over;
    end
  end

  pfe_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(lhs), .den(rhs),
    .done(div_done), .quot(quot)
  );

  assign sts.is_digit = (sym >= SymZero) && (sym <= SymNine);
  assign sts.op       = op;
  assign sts.rhs_zero = (rhs == '0);
  assign sts.div_done = div_done;
endmodule

// File: sv/pfe_ctrl.sv
// Sequencer for the evaluator: one word at a time through stack steps.
module pfe_ctrl import pfe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_last,
  output logic     out_valid,
  input  logic     out_ready,
  input  pfe_sts_t sts,
  output pfe_cmd_t cmd
);
  pfe_state_t state, state_next;
  logic       last, last_next;
  logic       ov, ov_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      last  <= 1'b0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      last  <= last_next;
      ov    <= ov_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    last_next  = last;
    ov_next    = ov;
    cmd        = '0;
    in_ready   = 1'b0;
    if (ov && out_ready) ov_next = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          last_next  = in_last;
          state_next = S_POP_R;
        end
      end
      S_POP_R: begin
        if (sts.is_digit) begin
          cmd.push_dig = 1'b1;
          state_next = last ? S_FIN_WAIT : S_IDLE;
        end else begin
          cmd.pop_rhs = 1'b1;
          state_next  = S_POP_WAIT;
        end
      end
      // let the registered top follow the lowered pointer
      S_POP_WAIT: state_next = S_POP_L;
      S_POP_L: begin
        cmd.pop_lhs = 1'b1;
        state_next  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.op == OP_DIV && !sts.rhs_zero) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = last ? S_FIN_WAIT : S_IDLE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_push = 1'b1;
          state_next = last ? S_FIN_WAIT : S_IDLE;
        end
      end
      S_FIN_WAIT: state_next = S_FIN_POP;
      S_FIN_POP: begin
        cmd.pop_fin = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (!ov || out_ready) begin
          cmd.fin_take = 1'b1;
          cmd.clear    = 1'b1;
          ov_next      = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid = ov;
endmodule

// File: sv/postfix_expression_evaluator.sv
// Top level: postfix expression evaluator on a 128-word operand stack.
// A digit passes S_IDLE, S_POP_R; an operator also S_POP_WAIT, S_POP_L, S_EXEC; the last word adds
// S_FIN_WAIT, S_FIN_POP, S_OUT to load the result. One word at a time; the 32-step divider is worst case.
// The result sits in an output register so the next word is taken while it waits.
// Reset (rst, synchronous) empties the stack and clears status and flags; no clearing pass.
module postfix_expression_evaluator import pfe_pkg::*; (
  input logic clk,
  input logic rst,
  pfe_in_if.sink    in,
  pfe_out_if.source out
);
  pfe_cmd_t cmd;
  pfe_sts_t sts;
  logic [31:0] val;

  pfe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
    .in_last(in.end_of_expr), .out_valid(out.valid), .out_ready(out.ready),
    .sts(sts), .cmd(cmd)
  );

  pfe_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .symbol(in.symbol),
    .res_value(val), .res_status(out.status), .res_under(out.underflow_seen),
    .res_over(out.overflow_seen)
  );

  assign out.value = signed'(val);

  // a held result keeps its value until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> $stable(out.value) && out.valid)
    else $error("result changed while stalled");
  // status is never the unused code
  a_stat: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> out.status <= StDivZero)
    else $error("bad status code");
  // input is taken only in the idle state
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    in.ready |-> !cmd.div_start && !cmd.pop_fin)
    else $error("ready while busy");
endmodule

// File: tb/postfix_expression_evaluator_tb.sv
// Testbench for the postfix expression evaluator: random and directed expressions, scoreboard.
module postfix_expression_evaluator_tb;
  import pfe_pkg::*;

  typedef struct {
    logic [7:0] symbol;
    logic       end_of_expr;
  } sym_word_t;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  status;
    logic        underflow_seen;
    logic        overflow_seen;
  } eval_result_t;

  logic clk;
  logic rst;

  pfe_in_if  in_ch (clk);
  pfe_out_if out_ch (clk);

  postfix_expression_evaluator u_top (
    .clk(clk),
    .rst(rst),
    .in(in_ch.sink),
    .out(out_ch.source)
  );

  sym_word_t    pending_words[$];
  eval_result_t expected_results[$];

  // predictor state
  logic [31:0] eval_stack[StackDepth];
  int          eval_count;
  logic [1:0]  eval_status;
  logic        eval_underflow;
  logic        eval_overflow;

  int  mismatches;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_cycles;
  bit  in_acc;
  longint cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] stack_pop();
    if (eval_count == 0) begin
      eval_underflow = 1'b1;
      return 32'hFFFF_FFFF;
    end
    eval_count--;
    return eval_stack[eval_count];
  endfunction

  function automatic void stack_push(logic [31:0] v);
    if (eval_count >= StackDepth) begin
      eval_overflow = 1'b1;
    end else begin
      eval_stack[eval_count] = v;
      eval_count++;
    end
  endfunction

  function automatic void record_error(logic [1:0] code);
    if (eval_status == StOk) eval_status = code;
  endfunction

  function automatic logic [31:0] trunc_quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // apply one accepted word to the predictor
  function automatic void evaluate_word(sym_word_t w);
    logic [31:0] rhs;
    logic [31:0] lhs;
    eval_result_t r;
    if (w.symbol >= SymZero && w.symbol <= SymNine) begin
      stack_push(32'(w.symbol - SymZero));
    end else begin
      rhs = stack_pop();
      lhs = stack_pop();
      case (w.symbol)
        SymAdd: stack_push(lhs + rhs);
        SymSub: stack_push(lhs - rhs);
        SymMul: stack_push(lhs * rhs);
        SymDiv: begin
          if (rhs == 32'd0) record_error(StDivZero);
          else stack_push(trunc_quotient(lhs, rhs));
        end
        SymXor: stack_push(lhs ^ rhs);
        default: record_error(StBadSym);
      endcase
    end
    if (w.end_of_expr) begin
      r.value = stack_pop();
      r.status = eval_status;
      r.underflow_seen = eval_underflow;
      r.overflow_seen = eval_overflow;
      expected_results.push_back(r);
      eval_count = 0;
      eval_status = StOk;
      eval_underflow = 1'b0;
      eval_overflow = 1'b0;
    end
  endfunction

  function automatic void add_word(logic [7:0] s, logic e);
    sym_word_t w;
    w.symbol = s;
    w.end_of_expr = e;
    pending_words.push_back(w);
  endfunction

  function automatic logic [7:0] rand_digit();
    return SymZero + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 4))
      0: return SymAdd;
      1: return SymSub;
      2: return SymMul;
      3: return SymDiv;
      default: return SymXor;
    endcase
  endfunction

  // expression that never underflows, with random content, mostly short
  function automatic void add_expression();
    int n;
    int depth;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 5);
    add_word(rand_digit(), 1'b0);
    depth = 1;
    for (int i = 0; i < n; i++) begin
      if (depth >= 2 && $urandom_range(0, 1)) begin
        add_word(rand_op(), 1'b0);
        depth--;
      end else begin
        add_word(rand_digit(), 1'b0);
        depth++;
      end
    end
    while (depth > 2) begin
      add_word(rand_op(), 1'b0);
      depth--;
    end
    if (depth == 2) add_word(rand_op(), 1'b1);
    else add_word(rand_digit(), 1'b1);
  endfunction

  // noise: random bytes, with the end mark on the last one
  function automatic void add_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      add_word(8'($urandom_range(0, 255)), (i == n - 1) ? 1'b1 : 1'b0);
    end
  endfunction

  function automatic void add_directed();
    // empty stack at end: underflow, value all ones
    add_word(SymAdd, 1'b1);
    // extremes of the symbol field, invalid symbols
    add_word(8'h00, 1'b1);
    add_word(8'hFF, 1'b1);
    // every operator
    add_word(SymZero + 8'd9, 1'b0); add_word(SymZero + 8'd4, 1'b0); add_word(SymAdd, 1'b1);
    add_word(SymZero + 8'd3, 1'b0); add_word(SymZero + 8'd7, 1'b0); add_word(SymSub, 1'b1);
    add_word(SymZero + 8'd8, 1'b0); add_word(SymZero + 8'd9, 1'b0); add_word(SymMul, 1'b1);
    add_word(SymZero + 8'd7, 1'b0); add_word(SymZero + 8'd2, 1'b0); add_word(SymDiv, 1'b1);
    add_word(SymZero + 8'd5, 1'b0); add_word(SymZero + 8'd6, 1'b0); add_word(SymXor, 1'b1);
    // division by zero, then a bad symbol: first error is kept
    add_word(SymZero + 8'd5, 1'b0); add_word(SymZero, 1'b0); add_word(SymDiv, 1'b0);
    add_word(8'h41, 1'b1);
    // negative quotient truncates toward zero: (0-7)/2
    add_word(SymZero, 1'b0); add_word(SymZero + 8'd7, 1'b0); add_word(SymSub, 1'b0);
    add_word(SymZero + 8'd2, 1'b0); add_word(SymDiv, 1'b1);
  endfunction

  // overflow the stack, and build most negative word divided by -1
  function automatic void add_deep_cases();
    for (int i = 0; i < StackDepth + 3; i++) add_word(SymZero + 8'd1, 1'b0);
    add_word(SymAdd, 1'b1);
    // 8^11 = 2^33 wraps; build 2^31 as 8^10*2 and -1 as 0 - 1
    add_word(SymZero + 8'd2, 1'b0);
    for (int i = 0; i < 10; i++) begin
      add_word(SymZero + 8'd8, 1'b0); add_word(SymMul, 1'b0);
    end
    add_word(SymZero, 1'b0); add_word(SymZero + 8'd1, 1'b0); add_word(SymSub, 1'b0);
    add_word(SymDiv, 1'b1);
  endfunction

  // note an input handshake at the rising edge
  always @(posedge clk) begin
    in_acc <= !rst && in_ch.valid && in_ch.ready;
  end

  // driver: change inputs at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.symbol <= 8'd0;
      in_ch.end_of_expr <= 1'b0;
    end else begin
      if (in_acc) void'(pending_words.pop_front());
      if (!in_ch.valid || in_acc) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.symbol <= pending_words[0].symbol;
          in_ch.end_of_expr <= pending_words[0].end_of_expr;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with a long hold-off when asked
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: predict on accepted input, check accepted output
  always @(posedge clk) begin
    eval_result_t exp_r;
    if (!rst) begin
      cycle_count <= cycle_count + 1;
      if (in_ch.valid && in_ch.ready) begin
        sym_word_t w;
        w.symbol = in_ch.symbol;
        w.end_of_expr = in_ch.end_of_expr;
        evaluate_word(w);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result value=%h", out_ch.value);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.value !== exp_r.value || out_ch.status !== exp_r.status ||
              out_ch.underflow_seen !== exp_r.underflow_seen ||
              out_ch.overflow_seen !== exp_r.overflow_seen) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp value=%h st=%0d uf=%b of=%b got value=%h st=%0d uf=%b of=%b",
                       exp_r.value, exp_r.status, exp_r.underflow_seen, exp_r.overflow_seen,
                       out_ch.value, out_ch.status, out_ch.underflow_seen,
                       out_ch.overflow_seen);
          end
        end
      end
    end
  end

  // end the run at a generous cycle limit
  always @(posedge clk) begin
    if (cycle_count > 2000000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic drain_queue();
    while (pending_words.size() > 0) @(posedge clk);
  endtask

  task automatic wait_results();
    while (expected_results.size() > 0) @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.symbol = 8'd0;
    in_ch.end_of_expr = 1'b0;
    out_ch.ready = 1'b0;
    rst = 1'b1;
    eval_count = 0;
    eval_status = StOk;
    eval_underflow = 1'b0;
    eval_overflow = 1'b0;
    mismatches = 0;
    hold_cycles = 0;
    cycle_count = 0;
    send_idle_pct = 14;
    recv_idle_pct = 75;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    add_directed();
    add_deep_cases();
    drain_queue();
    // pause the sender until every result is in
    wait_results();

    // long receiver hold-off while words keep flowing
    hold_cycles = 600;
    for (int i = 0; i < 20; i++) add_expression();
    for (int k = 0; k < 30; k++) begin
      if ($urandom_range(0, 4) == 0) add_noise();
      else add_expression();
    end
    drain_queue();

    send_idle_pct = 75;
    recv_idle_pct = 14;
    for (int k = 0; k < 40; k++) begin
      if ($urandom_range(0, 4) == 0) add_noise();
      else add_expression();
    end
    drain_queue();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < 40; k++) begin
      if ($urandom_range(0, 4) == 0) add_noise();
      else add_expression();
    end
    drain_queue();

    wait_results();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: postfix_expression_evaluator.f
sv/pfe_pkg.sv
sv/pfe_if.sv
sv/pfe_div.sv
sv/pfe_datapath.sv
sv/pfe_ctrl.sv
sv/postfix_expression_evaluator.sv
tb/postfix_expression_evaluator_tb.sv
